@@ design/irpd_pkg.sv @@
package irpd_pkg;

  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = $clog2(NumRegs);
  localparam int unsigned DurW = 16;

  localparam logic [DurW-1:0] FRAME_END_SPACE = 16'd25000;
  localparam logic [DurW-1:0] HDR_SPACE_MIN = 16'd1500;
  localparam logic [DurW-1:0] HDR_SPACE_MAX = 16'd1950;

  typedef enum logic [RegIdxW-1:0] {
    REG_HDR_PULSE_MIN = 3'd0,
    REG_HDR_PULSE_MAX = 3'd1,
    REG_BIT_PULSE_MIN = 3'd2,
    REG_BIT_PULSE_MAX = 3'd3,
    REG_ONE_SPACE_MIN = 3'd4,
    REG_ONE_SPACE_MAX = 3'd5,
    REG_ZERO_SPACE_MIN = 3'd6,
    REG_ZERO_SPACE_MAX = 3'd7
  } reg_idx_t;

  localparam logic [DurW-1:0] REG_RESET [NumRegs] = '{
    16'd3250, 16'd3650, 16'd375, 16'd800, 16'd1100, 16'd1400, 16'd200, 16'd550
  };

  typedef enum logic [1:0] {
    CMD_PULSE = 2'd0,
    CMD_SPACE = 2'd1,
    CMD_CARRIER = 2'd2,
    CMD_TIMEOUT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_SPACE_EARLY = 3'd0,
    ERR_PULSE_EARLY = 3'd1,
    ERR_PULSE_SHORT = 3'd2,
    ERR_PULSE_LONG = 3'd3,
    ERR_NO_HEADER = 3'd4,
    ERR_HDR_IN_FRAME = 3'd5,
    ERR_SPACE_RANGE = 3'd6
  } err_t;

endpackage

@@ design/ir_pulse_distance_decoder_unit.sv @@
// a word accepted into the input register is decoded there and its result is registered
// in the output register; a word with a result waits while an earlier result is not taken
// throughput: else one event word per cycle, limited by one decode stage and state update
// reset (rst, synchronous): decoder returns to idle, window registers take their defaults,
// input and output registers are emptied
module ir_pulse_distance_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // duration_us
  input  logic [1:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // data_byte [7:0], error_code [10:8], zero fill
  output logic [1:0]  m_tuser,   // result_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [irpd_pkg::RegIdxW-1:0] cfg_index,
  input  logic [irpd_pkg::DurW-1:0]    cfg_data
);

  logic [irpd_pkg::DurW-1:0] regs [irpd_pkg::NumRegs];

  logic                      in_valid;
  irpd_pkg::cmd_t            in_cmd;
  logic [irpd_pkg::DurW-1:0] in_dur;

  logic       expect_pulse, expect_pulse_next;
  logic       awaiting_header, awaiting_header_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [2:0] bit_count, bit_count_next;

  irpd_pkg::kind_t out_kind;
  logic [7:0]      out_byte;
  irpd_pkg::err_t  out_code;

  logic            has_res;
  irpd_pkg::kind_t res_kind;
  logic [7:0]      res_byte;
  irpd_pkg::err_t  res_code;
  logic            go_idle;
  logic            advance;

  logic hdr_pulse_win, one_win, zero_win, hdr_space_win;
  logic [7:0] bit_mask;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < irpd_pkg::NumRegs; i++) begin
        regs[i] <= irpd_pkg::REG_RESET[i];
      end
    end else if (cfg_valid && cfg_ready) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  assign hdr_pulse_win = in_dur >= regs[irpd_pkg::REG_HDR_PULSE_MIN] &&
                         in_dur <= regs[irpd_pkg::REG_HDR_PULSE_MAX];
  assign one_win = in_dur >= regs[irpd_pkg::REG_ONE_SPACE_MIN] &&
                   in_dur <= regs[irpd_pkg::REG_ONE_SPACE_MAX];
  assign zero_win = in_dur >= regs[irpd_pkg::REG_ZERO_SPACE_MIN] &&
                    in_dur <= regs[irpd_pkg::REG_ZERO_SPACE_MAX];
  assign hdr_space_win = in_dur >= irpd_pkg::HDR_SPACE_MIN &&
                         in_dur <= irpd_pkg::HDR_SPACE_MAX;
  assign bit_mask = 8'd1 << bit_count;

  // decode of the word held in the input register
  always_comb begin
    has_res = 1'b0;
    res_kind = irpd_pkg::KIND_BYTE;
    res_byte = 8'd0;
    res_code = irpd_pkg::ERR_SPACE_EARLY;
    go_idle = 1'b0;
    expect_pulse_next = expect_pulse;
    awaiting_header_next = awaiting_header;
    shift_byte_next = shift_byte;
    bit_count_next = bit_count;
    case (in_cmd)
      irpd_pkg::CMD_CARRIER: begin
        go_idle = 1'b1;
      end
      irpd_pkg::CMD_TIMEOUT: begin
        go_idle = 1'b1;
        has_res = 1'b1;
        res_kind = irpd_pkg::KIND_END;
      end
      irpd_pkg::CMD_PULSE: begin
        if (!expect_pulse) begin
          has_res = 1'b1;
          res_code = irpd_pkg::ERR_PULSE_EARLY;
        end else if (hdr_pulse_win) begin
          awaiting_header_next = 1'b1;
          expect_pulse_next = 1'b0;
        end else if (in_dur < regs[irpd_pkg::REG_BIT_PULSE_MIN]) begin
          has_res = 1'b1;
          res_code = irpd_pkg::ERR_PULSE_SHORT;
        end else if (in_dur > regs[irpd_pkg::REG_BIT_PULSE_MAX]) begin
          has_res = 1'b1;
          res_code = irpd_pkg::ERR_PULSE_LONG;
        end else begin
          expect_pulse_next = 1'b0;
        end
        if (has_res) begin
          res_kind = irpd_pkg::KIND_ERROR;
          go_idle = 1'b1;
        end
      end
      irpd_pkg::CMD_SPACE: begin
        if (expect_pulse) begin
          has_res = 1'b1;
          res_kind = irpd_pkg::KIND_ERROR;
          res_code = irpd_pkg::ERR_SPACE_EARLY;
          go_idle = 1'b1;
        end else if (in_dur >= irpd_pkg::FRAME_END_SPACE) begin
          has_res = 1'b1;
          res_kind = irpd_pkg::KIND_END;
          go_idle = 1'b1;
        end else if (one_win || zero_win) begin
          if (awaiting_header) begin
            has_res = 1'b1;
            res_kind = irpd_pkg::KIND_ERROR;
            res_code = irpd_pkg::ERR_NO_HEADER;
            go_idle = 1'b1;
          end else begin
            expect_pulse_next = 1'b1;
            shift_byte_next = one_win ? (shift_byte | bit_mask) : shift_byte;
            bit_count_next = bit_count + 3'd1;
            if (bit_count == 3'd7) begin
              has_res = 1'b1;
              res_kind = irpd_pkg::KIND_BYTE;
              res_byte = shift_byte_next;
              shift_byte_next = 8'd0;
            end
          end
        end else if (hdr_space_win) begin
          if (!awaiting_header) begin
            has_res = 1'b1;
            res_kind = irpd_pkg::KIND_ERROR;
            res_code = irpd_pkg::ERR_HDR_IN_FRAME;
            go_idle = 1'b1;
          end else begin
            awaiting_header_next = 1'b0;
            expect_pulse_next = 1'b1;
            shift_byte_next = 8'd0;
            bit_count_next = 3'd0;
          end
        end else begin
          has_res = 1'b1;
          res_kind = irpd_pkg::KIND_ERROR;
          res_code = irpd_pkg::ERR_SPACE_RANGE;
          go_idle = 1'b1;
        end
      end
      default: begin
        go_idle = 1'b1;
      end
    endcase
    if (go_idle) begin
      expect_pulse_next = 1'b1;
      awaiting_header_next = 1'b1;
      shift_byte_next = 8'd0;
      bit_count_next = 3'd0;
    end
  end

  // a word without a result never waits on the output register
  assign advance = in_valid && (!has_res || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd <= irpd_pkg::cmd_t'(s_tuser);
      in_dur <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_pulse <= 1'b1;
      awaiting_header <= 1'b1;
      shift_byte <= 8'd0;
      bit_count <= 3'd0;
    end else if (advance) begin
      expect_pulse <= expect_pulse_next;
      awaiting_header <= awaiting_header_next;
      shift_byte <= shift_byte_next;
      bit_count <= bit_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && has_res) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_res) begin
      out_kind <= res_kind;
      out_byte <= res_byte;
      out_code <= res_code;
    end
  end

  assign m_tuser = out_kind;
  assign m_tdata = {5'd0, out_code, out_byte};

endmodule
